// ===== hw/rtl/sbt_pkg.sv =====
package sbt_pkg;

    // Coordinate width of the Q16.16 fields.
    localparam int COORD_WIDTH = 32;
    localparam int HALF_WIDTH  = COORD_WIDTH - 1;

    // Projection end points, overlaps and their magnitudes.
    localparam int END_WIDTH = COORD_WIDTH + 3;
    localparam int OV_WIDTH  = COORD_WIDTH + 4;
    localparam int MAG_WIDTH = COORD_WIDTH + 4;

    // The magnitude is split in two halves for the narrow multipliers.
    localparam int SPLIT     = (MAG_WIDTH + 1) / 2;
    localparam int TOP_WIDTH = MAG_WIDTH - SPLIT;
    localparam int QA_WIDTH  = TOP_WIDTH - 2;
    localparam int VW        = SPLIT + 3;

    // Push candidates before saturation.
    localparam int PUSH_WIDTH = COORD_WIDTH + 6;

    // Number of register stages.
    localparam int STAGES = 8;

    // 1/sqrt(5) in Q0.32, and the reciprocal of five for values below 2^32.
    localparam logic [30:0] INV_SQRT5    = 31'd1920767767;
    localparam logic [31:0] RECIP5       = 32'hCCCCCCCD;
    localparam int          RECIP5_SHIFT = 34;

    typedef struct packed {
        logic                          mode;
        logic signed [COORD_WIDTH-1:0] player_x;
        logic signed [COORD_WIDTH-1:0] player_y;
        logic        [HALF_WIDTH-1:0]  player_half_w;
        logic        [HALF_WIDTH-1:0]  player_half_h;
        logic signed [COORD_WIDTH-1:0] obstacle_x;
        logic signed [COORD_WIDTH-1:0] obstacle_y;
        logic        [HALF_WIDTH-1:0]  obstacle_half_w;
        logic        [HALF_WIDTH-1:0]  obstacle_half_h;
    } t_in;

    typedef struct packed {
        logic                          collided;
        logic signed [COORD_WIDTH-1:0] push_x;
        logic signed [COORD_WIDTH-1:0] push_y;
    } t_out;

    // Result of one axis test.
    typedef struct packed {
        logic                       ok;
        logic signed [OV_WIDTH-1:0] ov;
    } t_axis;

    typedef struct packed {
        logic  mode;
        t_axis x;
        t_axis y;
        t_axis n0;
        t_axis n1;
    } t_axes;

    // Scaled magnitude and signed push of one diagonal axis.
    typedef struct packed {
        logic        [MAG_WIDTH-1:0]  t;
        logic signed [PUSH_WIDTH-1:0] px;
        logic signed [PUSH_WIDTH-1:0] py;
    } t_diag;

endpackage

// ===== hw/rtl/sat_box_vs_box_or_triangle_core.sv =====
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_data (sbt_pkg::t_in)
// result    out        o_valid / i_stall   o_data (sbt_pkg::t_out)
//
// Eight register stages; one pair enters per cycle when nothing stalls.
// The depth is set by the two-step division by five of the diagonal overlaps.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall holds only the stages that are full, so bubbles close up.
module sat_box_vs_box_or_triangle_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sbt_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output sbt_pkg::t_out o_data
);
    import sbt_pkg::*;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] en;
    t_axes             axes;
    t_diag             diag0;
    t_diag             diag1;

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    sbt_axes u_axes (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_item (i_data),
        .o_axes (axes)
    );

    sbt_diag u_diag0 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ov   (axes.n0.ov),
        .o_diag (diag0)
    );

    sbt_diag u_diag1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ov   (axes.n1.ov),
        .o_diag (diag1)
    );

    sbt_select u_select (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_axes   (axes),
        .i_n0     (diag0),
        .i_n1     (diag1),
        .o_result (o_data)
    );

    assign o_stall = !en[0];
    assign o_valid = r_vld[STAGES-1];

endmodule

// ===== hw/rtl/sbt_axes.sv =====
module sbt_axes (
    input  logic                        i_clk,
    input  logic [sbt_pkg::STAGES-1:0]  i_en,
    input  sbt_pkg::t_in                i_item,
    output sbt_pkg::t_axes              o_axes
);
    import sbt_pkg::*;

    typedef logic signed [END_WIDTH-1:0] t_end;

    function automatic t_axis f_overlap(input t_end lo0, input t_end hi0,
                                        input t_end lo1, input t_end hi1);
        t_axis                      res;
        logic signed [OV_WIDTH-1:0] s0;
        logic signed [OV_WIDTH-1:0] s1;
        s0 = OV_WIDTH'(lo0) + OV_WIDTH'(hi0);
        s1 = OV_WIDTH'(lo1) + OV_WIDTH'(hi1);
        res.ok = (lo1 < hi0) && (lo0 < hi1);
        if (s0 < s1) begin
            res.ov = OV_WIDTH'(lo1) - OV_WIDTH'(hi0);
        end else begin
            res.ov = OV_WIDTH'(hi1) - OV_WIDTH'(lo0);
        end
        return res;
    endfunction

    function automatic t_end f_min3(input t_end a, input t_end b, input t_end c);
        t_end m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic t_end f_max3(input t_end a, input t_end b, input t_end c);
        t_end m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    t_end px, py, hw, hh, ox, oy, ow, oh, pe;
    t_end pc [2];

    logic r_s1_mode;
    t_end r_s1_lo0 [4];
    t_end r_s1_hi0 [4];
    t_end r_s1_lo1 [2];
    t_end r_s1_hi1 [2];
    t_end r_s1_d1  [2];
    t_end r_s1_d2  [2];
    t_end r_s1_d3  [2];
    t_axes r_s2;

    // Widen the fields to the end point width.
    always_comb begin
        px = END_WIDTH'(i_item.player_x);
        py = END_WIDTH'(i_item.player_y);
        hw = $signed(END_WIDTH'(i_item.player_half_w));
        hh = $signed(END_WIDTH'(i_item.player_half_h));
        ox = END_WIDTH'(i_item.obstacle_x);
        oy = END_WIDTH'(i_item.obstacle_y);
        ow = $signed(END_WIDTH'(i_item.obstacle_half_w));
        oh = $signed(END_WIDTH'(i_item.obstacle_half_h));
        pe = (hw <<< 1) + hh;
        pc[0] = (px <<< 1) - py;
        pc[1] = (px <<< 1) + py;
    end

    // Stage one: projection end points on all four axes.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_mode   <= i_item.mode;
            r_s1_lo0[0] <= px - hw;
            r_s1_hi0[0] <= px + hw;
            r_s1_lo1[0] <= ox - ow;
            r_s1_hi1[0] <= ox + ow;
            r_s1_lo0[1] <= py - hh;
            r_s1_hi0[1] <= py + hh;
            r_s1_lo1[1] <= oy - oh;
            r_s1_hi1[1] <= oy + oh;
            r_s1_lo0[2] <= pc[0] - pe;
            r_s1_hi0[2] <= pc[0] + pe;
            r_s1_lo0[3] <= pc[1] - pe;
            r_s1_hi0[3] <= pc[1] + pe;
            r_s1_d1[0]  <= ((ox - ow) <<< 1) - (oy - oh);
            r_s1_d2[0]  <= ((ox + ow) <<< 1) - (oy - oh);
            r_s1_d3[0]  <= (ox <<< 1) - (oy + oh);
            r_s1_d1[1]  <= ((ox - ow) <<< 1) + (oy - oh);
            r_s1_d2[1]  <= ((ox + ow) <<< 1) + (oy - oh);
            r_s1_d3[1]  <= (ox <<< 1) + (oy + oh);
        end
    end

    // Stage two: interval tests and signed overlaps.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s2.mode <= r_s1_mode;
            r_s2.x    <= f_overlap(r_s1_lo0[0], r_s1_hi0[0], r_s1_lo1[0], r_s1_hi1[0]);
            r_s2.y    <= f_overlap(r_s1_lo0[1], r_s1_hi0[1], r_s1_lo1[1], r_s1_hi1[1]);
            r_s2.n0   <= f_overlap(r_s1_lo0[2], r_s1_hi0[2],
                             f_min3(r_s1_d1[0], r_s1_d2[0], r_s1_d3[0]),
                             f_max3(r_s1_d1[0], r_s1_d2[0], r_s1_d3[0]));
            r_s2.n1   <= f_overlap(r_s1_lo0[3], r_s1_hi0[3],
                             f_min3(r_s1_d1[1], r_s1_d2[1], r_s1_d3[1]),
                             f_max3(r_s1_d1[1], r_s1_d2[1], r_s1_d3[1]));
        end
    end

    assign o_axes = r_s2;

endmodule

// ===== hw/rtl/sbt_diag.sv =====
module sbt_diag (
    input  logic                              i_clk,
    input  logic [sbt_pkg::STAGES-1:0]        i_en,
    input  logic signed [sbt_pkg::OV_WIDTH-1:0] i_ov,
    output sbt_pkg::t_diag                    o_diag
);
    import sbt_pkg::*;

    localparam int SUM_WIDTH = MAG_WIDTH + 32;

    logic [MAG_WIDTH-1:0]      r_s3_m;
    logic                      r_s3_neg;

    logic [MAG_WIDTH-1:0]      r_s4_m;
    logic [SPLIT+30:0]         r_s4_pl;
    logic [TOP_WIDTH+30:0]     r_s4_ph;
    logic [QA_WIDTH-1:0]       r_s4_qa;
    logic                      r_s4_neg;

    logic [MAG_WIDTH-1:0]      r_s5_t;
    logic [VW-1:0]             r_s5_v;
    logic [QA_WIDTH-1:0]       r_s5_qa;
    logic                      r_s5_neg;

    logic [MAG_WIDTH-1:0]      r_s6_t;
    logic [VW-1:0]             r_s6_v;
    logic [QA_WIDTH-1:0]       r_s6_qa;
    logic [SPLIT-1:0]          r_s6_qv;
    logic                      r_s6_neg;

    t_diag                     r_s7;

    logic [TOP_WIDTH+31:0]     qa_prod;
    logic [SUM_WIDTH-1:0]      sum;
    logic [TOP_WIDTH-1:0]      ra_full;
    logic [VW+31:0]            qv_prod;
    logic [VW-1:0]             rem_full;
    logic [2:0]                rem;
    logic [MAG_WIDTH-1:0]      q1;
    logic [MAG_WIDTH-1:0]      q1r;
    logic [MAG_WIDTH:0]        q2r;
    logic [1:0]                q2_inc;

    // Stage three: magnitude and sign of the overlap.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s3_m   <= MAG_WIDTH'(i_ov[OV_WIDTH-1] ? -i_ov : i_ov);
            r_s3_neg <= i_ov[OV_WIDTH-1];
        end
    end

    // Stage four: partial products for 1/sqrt(5), top quotient by five.
    assign qa_prod = r_s3_m[MAG_WIDTH-1:SPLIT] * RECIP5;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s4_m   <= r_s3_m;
            r_s4_pl  <= r_s3_m[SPLIT-1:0] * INV_SQRT5;
            r_s4_ph  <= r_s3_m[MAG_WIDTH-1:SPLIT] * INV_SQRT5;
            r_s4_qa  <= qa_prod[TOP_WIDTH+31:RECIP5_SHIFT];
            r_s4_neg <= r_s3_neg;
        end
    end

    // Stage five: rounded sum of the partial products, remainder of the top half.
    assign sum = (SUM_WIDTH'(r_s4_ph) << SPLIT) + SUM_WIDTH'(r_s4_pl)
               + (SUM_WIDTH'(1) << 31);
    assign ra_full = r_s4_m[MAG_WIDTH-1:SPLIT]
                   - (TOP_WIDTH'(r_s4_qa) * TOP_WIDTH'(5));

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s5_t   <= sum[SUM_WIDTH-1:32];
            r_s5_v   <= {ra_full[2:0], r_s4_m[SPLIT-1:0]};
            r_s5_qa  <= r_s4_qa;
            r_s5_neg <= r_s4_neg;
        end
    end

    // Stage six: low quotient by five.
    assign qv_prod = r_s5_v * RECIP5;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_s6_t   <= r_s5_t;
            r_s6_v   <= r_s5_v;
            r_s6_qa  <= r_s5_qa;
            r_s6_qv  <= qv_prod[SPLIT+RECIP5_SHIFT-1:RECIP5_SHIFT];
            r_s6_neg <= r_s5_neg;
        end
    end

    // Stage seven: round m/5 and 2m/5 from the quotient and remainder.
    always_comb begin
        rem_full = r_s6_v - (VW'(r_s6_qv) * VW'(5));
        rem      = rem_full[2:0];
        q1       = MAG_WIDTH'({r_s6_qa, r_s6_qv});
        case (rem)
            3'd2, 3'd3: q2_inc = 2'd1;
            3'd4:       q2_inc = 2'd2;
            default:    q2_inc = 2'd0;
        endcase
        q1r = q1 + MAG_WIDTH'(rem >= 3'd3);
        q2r = {q1, 1'b0} + (MAG_WIDTH + 1)'(q2_inc);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_s7.t <= r_s6_t;
            if (r_s6_neg) begin
                r_s7.px <= -$signed(PUSH_WIDTH'(q2r));
                r_s7.py <= -$signed(PUSH_WIDTH'(q1r));
            end else begin
                r_s7.px <= $signed(PUSH_WIDTH'(q2r));
                r_s7.py <= $signed(PUSH_WIDTH'(q1r));
            end
        end
    end

    assign o_diag = r_s7;

endmodule

// ===== hw/rtl/sbt_select.sv =====
module sbt_select (
    input  logic                        i_clk,
    input  logic [sbt_pkg::STAGES-1:0]  i_en,
    input  sbt_pkg::t_axes              i_axes,
    input  sbt_pkg::t_diag              i_n0,
    input  sbt_pkg::t_diag              i_n1,
    output sbt_pkg::t_out               o_result
);
    import sbt_pkg::*;

    typedef struct packed {
        logic                       okxy;
        logic                       ok0;
        logic                       ok1;
        logic                       mode;
        logic [MAG_WIDTH-1:0]       best;
        logic signed [OV_WIDTH-1:0] bx;
        logic signed [OV_WIDTH-1:0] by;
    } t_xy;

    function automatic logic signed [COORD_WIDTH-1:0] f_sat(
        input logic signed [PUSH_WIDTH-1:0] v);
        logic [PUSH_WIDTH-COORD_WIDTH:0] upper;
        upper = v[PUSH_WIDTH-1:COORD_WIDTH-1];
        if (upper == '0 || upper == '1) begin
            return v[COORD_WIDTH-1:0];
        end else if (v[PUSH_WIDTH-1]) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    logic [MAG_WIDTH-1:0]       r_s3_mx;
    logic [MAG_WIDTH-1:0]       r_s3_my;
    t_axes                      r_s3;
    t_xy                        r_s4;
    t_xy                        r_s5;
    t_xy                        r_s6;
    t_xy                        r_s7;
    t_out                       r_s8;

    logic [MAG_WIDTH-1:0]       best;
    logic signed [PUSH_WIDTH-1:0] bx;
    logic signed [PUSH_WIDTH-1:0] by;
    logic                       hit;

    // Stage three: magnitudes of the x and y overlaps.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s3    <= i_axes;
            r_s3_mx <= MAG_WIDTH'(i_axes.x.ov[OV_WIDTH-1] ? -i_axes.x.ov : i_axes.x.ov);
            r_s3_my <= MAG_WIDTH'(i_axes.y.ov[OV_WIDTH-1] ? -i_axes.y.ov : i_axes.y.ov);
        end
    end

    // Stage four: the y axis wins only with a strictly smaller overlap.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s4.okxy <= r_s3.x.ok && r_s3.y.ok;
            r_s4.ok0  <= r_s3.n0.ok;
            r_s4.ok1  <= r_s3.n1.ok;
            r_s4.mode <= r_s3.mode;
            if (r_s3_my < r_s3_mx) begin
                r_s4.best <= r_s3_my;
                r_s4.bx   <= '0;
                r_s4.by   <= r_s3.y.ov;
            end else begin
                r_s4.best <= r_s3_mx;
                r_s4.bx   <= r_s3.x.ov;
                r_s4.by   <= '0;
            end
        end
    end

    // Stages five to seven wait for the diagonal axes.
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s5 <= r_s4;
        end
        if (i_en[5]) begin
            r_s6 <= r_s5;
        end
        if (i_en[6]) begin
            r_s7 <= r_s6;
        end
    end

    // Stage eight: diagonal axes in order, then the collision flag and saturation.
    always_comb begin
        best = r_s7.best;
        bx   = PUSH_WIDTH'(r_s7.bx);
        by   = PUSH_WIDTH'(r_s7.by);
        if (r_s7.mode) begin
            if (i_n0.t < best) begin
                best = i_n0.t;
                bx   = i_n0.px;
                by   = -i_n0.py;
            end
            if (i_n1.t < best) begin
                best = i_n1.t;
                bx   = i_n1.px;
                by   = i_n1.py;
            end
        end
        hit = r_s7.okxy && (!r_s7.mode || (r_s7.ok0 && r_s7.ok1));
        if (!hit) begin
            bx = '0;
            by = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_s8.collided <= hit;
            r_s8.push_x   <= f_sat(bx);
            r_s8.push_y   <= f_sat(by);
        end
    end

    assign o_result = r_s8;

endmodule

// ===== verif/sat_box_vs_box_or_triangle_core_tb.sv =====
`timescale 1ns / 100ps

module sat_box_vs_box_or_triangle_core_tb;
    import sbt_pkg::*;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_in   i_data;
    logic  o_valid;
    logic  i_stall;
    t_out  o_data;

    localparam bit MODE_BOX = 1'b0;
    localparam bit MODE_TRI = 1'b1;
    localparam int N_RANDOM = 1930;

    // A directed row, with an optional typed-in expectation.
    typedef struct {
        t_in  pair;
        bit   fixed;
        t_out want;
    } t_row;

    t_out  pending_pushes[$];
    int    fail_count;
    bit    stim_done;
    bit    long_hold;
    bit    hold_wanted;

    sat_box_vs_box_or_triangle_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    // Strict interval overlap; returns the signed penetration depth.
    function automatic bit interval_hit(longint lo0, longint hi0, longint lo1, longint hi1,
                                        output longint depth);
        depth = 0;
        if (!(lo1 < hi0 && lo0 < hi1)) return 1'b0;
        depth = (lo0 + hi0 < lo1 + hi1) ? lo1 - hi0 : hi1 - lo0;
        return 1'b1;
    endfunction

    function automatic longint clamp_coord(longint v);
        longint top;
        top = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        if (v > top) return top;
        if (v < -top - 1) return -top - 1;
        return v;
    endfunction

    // round(m / sqrt5) using the Q0.32 constant, halves rounded up.
    function automatic longint shrink_by_root5(longint m);
        logic [127:0] prod;
        prod = 128'(m) * 128'(INV_SQRT5) + (128'd1 << 31);
        return longint'(prod >> 32);
    endfunction

    // Minimum translation vector of the player for one pair.
    function automatic t_out separate_pair(t_in p);
        t_out   r;
        longint px, py, hw, hh, ox, oy, ow, oh;
        longint depth, best, bx, by, pc, pe, d1, d2, d3, lo, hi, m, t, s, sg;
        bit     hit;
        px = p.player_x;   py = p.player_y;
        hw = p.player_half_w;   hh = p.player_half_h;
        ox = p.obstacle_x; oy = p.obstacle_y;
        ow = p.obstacle_half_w; oh = p.obstacle_half_h;
        best = 0; bx = 0; by = 0;
        hit = interval_hit(px - hw, px + hw, ox - ow, ox + ow, depth);
        if (hit) begin
            best = depth < 0 ? -depth : depth;
            bx = depth;
            hit = interval_hit(py - hh, py + hh, oy - oh, oy + oh, depth);
            if (hit && (depth < 0 ? -depth : depth) < best) begin
                best = depth < 0 ? -depth : depth;
                bx = 0;
                by = depth;
            end
        end
        // The two triangle side normals, left side first.
        for (int k = 0; k < 2; k++) begin
            if (hit && p.mode == MODE_TRI) begin
                s  = k ? 1 : -1;
                pc = 2 * px + s * py;
                pe = 2 * hw + hh;
                d1 = 2 * (ox - ow) + s * (oy - oh);
                d2 = 2 * (ox + ow) + s * (oy - oh);
                d3 = 2 * ox + s * (oy + oh);
                lo = d1 < d2 ? d1 : d2;
                lo = lo < d3 ? lo : d3;
                hi = d1 > d2 ? d1 : d2;
                hi = hi > d3 ? hi : d3;
                hit = interval_hit(pc - pe, pc + pe, lo, hi, depth);
                if (hit) begin
                    m = depth < 0 ? -depth : depth;
                    t = shrink_by_root5(m);
                    if (t < best) begin
                        sg = depth < 0 ? -1 : 1;
                        best = t;
                        bx = sg * ((4 * m + 5) / 10);
                        by = sg * s * ((2 * m + 5) / 10);
                    end
                end
            end
        end
        r.collided = hit;
        r.push_x = hit ? COORD_WIDTH'(clamp_coord(bx)) : '0;
        r.push_y = hit ? COORD_WIDTH'(clamp_coord(by)) : '0;
        return r;
    endfunction

    function automatic t_in make_pair(bit mode, longint px, longint py, longint hw,
                                      longint hh, longint ox, longint oy, longint ow,
                                      longint oh);
        t_in p;
        p.mode = mode;
        p.player_x = COORD_WIDTH'(px); p.player_y = COORD_WIDTH'(py);
        p.player_half_w = HALF_WIDTH'(hw); p.player_half_h = HALF_WIDTH'(hh);
        p.obstacle_x = COORD_WIDTH'(ox); p.obstacle_y = COORD_WIDTH'(oy);
        p.obstacle_half_w = HALF_WIDTH'(ow); p.obstacle_half_h = HALF_WIDTH'(oh);
        return p;
    endfunction

    // Random pair: mostly close shapes of modest size, sometimes raw noise.
    function automatic t_in random_pair();
        t_in          p;
        int           kind;
        logic [255:0] raw;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom};
            p = raw[$bits(t_in)-1:0];
        end else begin
            p.mode = 1'($urandom_range(0, 1));
            p.player_x = $signed($urandom) >>> $urandom_range(0, 14);
            p.player_y = $signed($urandom) >>> $urandom_range(0, 14);
            p.player_half_w = HALF_WIDTH'($urandom >> $urandom_range(1, 16));
            p.player_half_h = HALF_WIDTH'($urandom >> $urandom_range(1, 16));
            p.obstacle_x = p.player_x + ($signed($urandom) >>> $urandom_range(12, 20));
            p.obstacle_y = p.player_y + ($signed($urandom) >>> $urandom_range(12, 20));
            p.obstacle_half_w = HALF_WIDTH'($urandom >> $urandom_range(1, 16));
            p.obstacle_half_h = HALF_WIDTH'($urandom >> $urandom_range(1, 16));
            if (kind == 1) p.player_x = p.obstacle_x;
        end
        return p;
    endfunction

    t_row rows[$];

    task automatic add_row(t_in p, bit fixed = 0, bit c = 0, longint x = 0, longint y = 0);
        t_row r;
        r.pair = p;
        r.fixed = fixed;
        r.want.collided = c;
        r.want.push_x = COORD_WIDTH'(x);
        r.want.push_y = COORD_WIDTH'(y);
        rows.insert(rows.size(), r);
    endtask

    task automatic send_pair(t_in p, t_out want);
        i_valid <= 1'b1;
        i_data  <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_pushes.insert(pending_pushes.size(), want);
    endtask

    // Random gap between bursts.
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stimulus.
    initial begin
        t_in  p;
        int   burst;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        stim_done = 0;
        hold_wanted = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows.
        add_row(make_pair(MODE_BOX, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, 0, 0);
        add_row(make_pair(MODE_BOX, 0, 0, 65536, 65536, 131072, 0, 65536, 65536),
                1'b1, 1'b0, 0, 0);
        add_row(make_pair(MODE_BOX, 0, 0, 65536, 65536, 65536, 0, 65536, 65536),
                1'b1, 1'b1, -65536, 0);
        add_row(make_pair(MODE_BOX, 0, 0, 65536, 65536, -65536, 0, 65536, 65536),
                1'b1, 1'b1, 65536, 0);
        add_row(make_pair(MODE_BOX, 0, 0, 65536, 65536, 0, 32768, 65536, 65536),
                1'b1, 1'b1, 0, -98304);
        add_row(make_pair(MODE_BOX, 0, 0, 65536, 65536, 0, 0, 65536, 65536),
                1'b1, 1'b1, 131072, 0);
        add_row(make_pair(MODE_BOX, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF,
                          31'h7FFFFFFF, -32'sh80000000, -32'sh80000000,
                          31'h7FFFFFFF, 31'h7FFFFFFF));
        add_row(make_pair(MODE_TRI, -32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF,
                          31'h7FFFFFFF, 32'sh7FFFFFFF, -32'sh80000000,
                          31'h7FFFFFFF, 31'h7FFFFFFF));
        add_row(make_pair(MODE_BOX, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0,
                          31'h7FFFFFFF, 31'h7FFFFFFF), 1'b1, 1'b1, 32'sh7FFFFFFF, 0);
        add_row(make_pair(MODE_TRI, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0,
                          31'h7FFFFFFF, 31'h7FFFFFFF));
        add_row(make_pair(MODE_TRI, 0, 0, 65536, 65536, 0, 0, 65536, 65536));
        add_row(make_pair(MODE_TRI, -120000, 60000, 32768, 32768, 0, 0, 65536, 65536));
        add_row(make_pair(MODE_TRI, 120000, 60000, 32768, 32768, 0, 0, 65536, 65536));
        add_row(make_pair(MODE_TRI, 90000, 90000, 32768, 32768, 0, 0, 65536, 65536));
        add_row(make_pair(MODE_TRI, -90000, 90000, 32768, 32768, 0, 0, 65536, 65536));
        add_row(make_pair(MODE_TRI, 3, 7, 5, 2, 0, 0, 4, 6));
        add_row(make_pair(MODE_TRI, -3, -1, 1, 1, 0, 0, 3, 3));
        for (int i = 0; i < rows.size(); i++)
            send_pair(rows[i].pair, rows[i].fixed ? rows[i].want : separate_pair(rows[i].pair));

        // Random traffic in bursts; a long receiver hold part way through.
        burst = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 400) hold_wanted = 1;
            if (i == 1000) begin
                // Let the pipeline drain completely before carrying on.
                i_valid <= 1'b0;
                while (pending_pushes.size() != 0) @(posedge i_clk);
            end
            if (burst == 0) begin
                idle_gap();
                burst = $urandom_range(1, 40);
            end
            burst--;
            p = random_pair();
            send_pair(p, separate_pair(p));
        end
        i_valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver stall pattern, with one long hold.
    initial begin
        int hold_left;
        int phase;
        i_stall = 1'b0;
        long_hold = 0;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_wanted && !long_hold) begin
                long_hold = 1;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                phase = (phase + 1) % 256;
                i_stall <= phase >= 128 ? 1'b0 : ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Result checking.
    initial begin
        t_out want;
        fail_count = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_pushes.size() == 0) begin
                    $error("unexpected result transfer %p", o_data);
                    fail_count++;
                end else begin
                    want = pending_pushes.pop_front();
                    if (o_data.collided !== want.collided) begin
                        $error("collided: expected %0d, got %0d", want.collided, o_data.collided);
                        fail_count++;
                    end
                    if (o_data.push_x !== want.push_x) begin
                        $error("push_x: expected %0d, got %0d", want.push_x, o_data.push_x);
                        fail_count++;
                    end
                    if (o_data.push_y !== want.push_y) begin
                        $error("push_y: expected %0d, got %0d", want.push_y, o_data.push_y);
                        fail_count++;
                    end
                end
            end
        end
    end

    // End of run.
    initial begin
        wait (stim_done);
        while (pending_pushes.size() != 0) @(posedge i_clk);
        repeat (4 * STAGES) @(posedge i_clk);
        if (fail_count == 0 && pending_pushes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sbt_pkg.sv
hw/rtl/sbt_axes.sv
hw/rtl/sbt_diag.sv
hw/rtl/sbt_select.sv
hw/rtl/sat_box_vs_box_or_triangle_core.sv
verif/sat_box_vs_box_or_triangle_core_tb.sv
